@@ design/afv_pkg.sv @@
package afv_pkg;

  // calibration table size, clamped to the 2..16 points the table holds
  localparam int TABLE_POINTS = 9;
  localparam int NPTS = (TABLE_POINTS < 2) ? 2 : ((TABLE_POINTS > 16) ? 16 : TABLE_POINTS);

  localparam int RAW_W  = 12;
  localparam int VEL_W  = 13;
  localparam int SEG_W  = 4;
  localparam int DV_W   = 11;
  localparam int NUM_W  = DV_W + RAW_W;
  localparam int RCP_W  = 25;
  localparam int PROD_W = NUM_W + RCP_W;
  localparam int RECIP_SHIFT = 31;

  // status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CHECKSUM = 3'd1;
  localparam logic [2:0] ST_RANGE    = 3'd2;
  localparam logic [2:0] ST_BUS      = 3'd3;
  localparam logic [2:0] ST_MODEL    = 3'd4;

  // calibration points, raw count and mm/s
  localparam logic [RAW_W-1:0] CAL_ADC [16] = '{
    12'd409, 12'd915, 12'd1522, 12'd2066, 12'd2523, 12'd2908, 12'd3256, 12'd3572,
    12'd3686, 12'd3686, 12'd3686, 12'd3686, 12'd3686, 12'd3686, 12'd3686, 12'd3686
  };
  localparam logic [VEL_W-1:0] CAL_VEL [16] = '{
    13'd0, 13'd1070, 13'd2010, 13'd3000, 13'd3970, 13'd4960, 13'd5980, 13'd6990,
    13'd7230, 13'd7230, 13'd7230, 13'd7230, 13'd7230, 13'd7230, 13'd7230, 13'd7230
  };

  // per-segment reciprocal of the raw span, floor(2^31 / span) + 1
  // exact quotient for numerators below 2^20; flat segments carry a dummy
  localparam logic [RCP_W-1:0] RECIP [16] = '{
    RCP_W'((64'd1 << RECIP_SHIFT) / 64'(CAL_ADC[1] - CAL_ADC[0]) + 64'd1),
    RCP_W'((64'd1 << RECIP_SHIFT) / 64'(CAL_ADC[2] - CAL_ADC[1]) + 64'd1),
    RCP_W'((64'd1 << RECIP_SHIFT) / 64'(CAL_ADC[3] - CAL_ADC[2]) + 64'd1),
    RCP_W'((64'd1 << RECIP_SHIFT) / 64'(CAL_ADC[4] - CAL_ADC[3]) + 64'd1),
    RCP_W'((64'd1 << RECIP_SHIFT) / 64'(CAL_ADC[5] - CAL_ADC[4]) + 64'd1),
    RCP_W'((64'd1 << RECIP_SHIFT) / 64'(CAL_ADC[6] - CAL_ADC[5]) + 64'd1),
    RCP_W'((64'd1 << RECIP_SHIFT) / 64'(CAL_ADC[7] - CAL_ADC[6]) + 64'd1),
    RCP_W'((64'd1 << RECIP_SHIFT) / 64'(CAL_ADC[8] - CAL_ADC[7]) + 64'd1),
    25'd1, 25'd1, 25'd1, 25'd1, 25'd1, 25'd1, 25'd1, 25'd1
  };

  // frame check result handed from the front stage to the interpolator
  typedef struct packed {
    logic [2:0]       status;
    logic [RAW_W-1:0] raw;
    logic [SEG_W-1:0] seg;
  } front_t;

endpackage

@@ design/afv_front.sv @@
module afv_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             sensor_model,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             bus_ok,
  input  logic [7:0]       checksum_byte,
  input  logic [7:0]       raw_high_byte,
  input  logic [7:0]       raw_low_byte,
  input  logic [7:0]       trailer_byte_a,
  input  logic [7:0]       trailer_byte_b,
  output logic             front_valid,
  input  logic             front_ready,
  output afv_pkg::front_t  front
);
  import afv_pkg::*;

  logic [7:0]       sum;
  logic [RAW_W-1:0] raw;
  logic [SEG_W-1:0] seg;
  logic [2:0]       st;
  logic             en;

  // modulo-256 byte sum and raw count
  assign sum = checksum_byte + raw_high_byte + raw_low_byte + trailer_byte_a + trailer_byte_b;
  assign raw = {raw_high_byte[3:0], raw_low_byte};

  // segment search: largest point below raw, parallel compares
  always_comb begin
    seg = '0;
    for (int i = 0; i < NPTS - 1; i++) begin
      if (raw > CAL_ADC[i]) seg = SEG_W'(i);
    end
  end

  // error priority
  always_comb begin
    if (!bus_ok) begin
      st = ST_BUS;
    end else if (sum != 8'd0) begin
      st = ST_CHECKSUM;
    end else if (sensor_model) begin
      st = ST_MODEL;
    end else if (raw < CAL_ADC[0] || raw > CAL_ADC[NPTS-1]) begin
      st = ST_RANGE;
    end else begin
      st = ST_OK;
    end
  end

  assign en       = !front_valid || front_ready;
  assign in_ready = en;

  // stage register
  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (en) begin
      front_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      front.status <= st;
      front.raw    <= raw;
      front.seg    <= seg;
    end
  end

  a_ok_in_range: assert property (@(posedge clk) disable iff (rst)
    front_valid && front.status == ST_OK |->
      front.raw >= CAL_ADC[0] && front.raw <= CAL_ADC[NPTS-1])
    else $error("ok frame with raw count outside table");

  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    front_valid && front.status == ST_OK |->
      front.seg <= SEG_W'(NPTS - 2) && front.raw >= CAL_ADC[front.seg])
    else $error("segment index does not bracket raw count");

endmodule

@@ design/afv_interp.sv @@
module afv_interp (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      front_valid,
  output logic                      front_ready,
  input  afv_pkg::front_t           front,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [afv_pkg::VEL_W-1:0] velocity_mm_s,
  output logic [2:0]                status
);
  import afv_pkg::*;

  logic [SEG_W-1:0]  seg_hi;
  logic [RAW_W-1:0]  lo_a, hi_a;
  logic [VEL_W-1:0]  lo_v, hi_v;
  logic              ok, live;

  logic              v2, v3, v4;
  logic              en2, en3, en4, en5;

  logic [DV_W-1:0]   s2_dv;
  logic [RAW_W-1:0]  s2_dr;
  logic [VEL_W-1:0]  s2_lo_v;
  logic [RCP_W-1:0]  s2_recip;
  logic [2:0]        s2_status;

  logic [NUM_W-1:0]  s3_num;
  logic [VEL_W-1:0]  s3_lo_v;
  logic [RCP_W-1:0]  s3_recip;
  logic [2:0]        s3_status;

  logic [PROD_W-1:0] s4_prod;
  logic [VEL_W-1:0]  s4_lo_v;
  logic [2:0]        s4_status;

  // stage enables, a stage loads when empty or when its successor moves
  assign en5 = !out_valid || out_ready;
  assign en4 = !v4 || en5;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign front_ready = en2;

  // segment endpoints from the calibration table
  assign seg_hi = front.seg + SEG_W'(1);
  assign lo_a   = CAL_ADC[front.seg];
  assign hi_a   = CAL_ADC[seg_hi];
  assign lo_v   = CAL_VEL[front.seg];
  assign hi_v   = CAL_VEL[seg_hi];
  assign ok     = front.status == ST_OK;
  // flat or inverted segment contributes the lower point only
  assign live   = ok && hi_a > lo_a && front.raw >= lo_a && hi_v >= lo_v;

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en2) v2 <= front_valid;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
      if (en5) out_valid <= v4;
    end
  end

  // stage 2: spans and reciprocal, errors zero the velocity terms
  always_ff @(posedge clk) begin
    if (en2 && front_valid) begin
      s2_dv     <= live ? DV_W'(hi_v - lo_v) : '0;
      s2_dr     <= front.raw - lo_a;
      s2_lo_v   <= ok ? lo_v : '0;
      s2_recip  <= RECIP[front.seg];
      s2_status <= front.status;
    end
  end

  // stage 3: numerator, velocity span times raw offset
  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_num    <= NUM_W'(s2_dv) * NUM_W'(s2_dr);
      s3_lo_v   <= s2_lo_v;
      s3_recip  <= s2_recip;
      s3_status <= s2_status;
    end
  end

  // stage 4: divide by the raw span through its reciprocal
  always_ff @(posedge clk) begin
    if (en4 && v3) begin
      s4_prod   <= PROD_W'(s3_num) * PROD_W'(s3_recip);
      s4_lo_v   <= s3_lo_v;
      s4_status <= s3_status;
    end
  end

  // stage 5: output register
  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      velocity_mm_s <= s4_lo_v + VEL_W'(s4_prod[RECIP_SHIFT +: DV_W]);
      status        <= s4_status;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> velocity_mm_s == '0)
    else $error("error transaction with nonzero velocity");

  a_vel_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> velocity_mm_s <= CAL_VEL[NPTS-1])
    else $error("velocity above table maximum");

  a_err_dv: assert property (@(posedge clk) disable iff (rst)
    en3 && v2 && s2_status != ST_OK |=> s3_num == '0 && s3_lo_v == '0)
    else $error("error transaction carried velocity terms");

endmodule

@@ design/airflow_frame_to_velocity.sv @@
// channel  | handshake               | payload
// ---------+-------------------------+---------------------------------------------
// cfg      | cfg_we                  | cfg_data (sensor_model)
// in       | in_valid / in_ready     | bus_ok, checksum_byte, raw_high_byte,
//          |                         | raw_low_byte, trailer_byte_a, trailer_byte_b
// out      | out_valid / out_ready   | velocity_mm_s, status
//
// one transaction per cycle sustained while out_ready is high; input accept
// to output valid passes through five register stages (frame check, table
// lookup, two multiplies, output register)
// rst clears all valid bits and sets sensor_model to 0
// a stall at out_ready holds every stage; empty stages still fill, so up to
// five transactions sit in flight

module airflow_frame_to_velocity (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic                      cfg_data,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      bus_ok,
  input  logic [7:0]                checksum_byte,
  input  logic [7:0]                raw_high_byte,
  input  logic [7:0]                raw_low_byte,
  input  logic [7:0]                trailer_byte_a,
  input  logic [7:0]                trailer_byte_b,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [afv_pkg::VEL_W-1:0] velocity_mm_s,
  output logic [2:0]                status
);
  import afv_pkg::*;

  logic   sensor_model;
  logic   front_valid;
  logic   front_ready;
  front_t front;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sensor_model <= 1'b0;
    end else if (cfg_we) begin
      sensor_model <= cfg_data;
    end
  end

  // frame check and segment search
  afv_front u_front (
    .clk            (clk),
    .rst            (rst),
    .sensor_model   (sensor_model),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .bus_ok         (bus_ok),
    .checksum_byte  (checksum_byte),
    .raw_high_byte  (raw_high_byte),
    .raw_low_byte   (raw_low_byte),
    .trailer_byte_a (trailer_byte_a),
    .trailer_byte_b (trailer_byte_b),
    .front_valid    (front_valid),
    .front_ready    (front_ready),
    .front          (front)
  );

  // interpolation pipeline
  afv_interp u_interp (
    .clk           (clk),
    .rst           (rst),
    .front_valid   (front_valid),
    .front_ready   (front_ready),
    .front         (front),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .velocity_mm_s (velocity_mm_s),
    .status        (status)
  );

endmodule
